>>> rtl/escc_pkg.sv
package escc_pkg;

  typedef struct packed {
    logic        operation;
    logic [31:0] seconds_count;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [31:0] out_seconds_count;
    logic        invalid;
  } out_item_t;

  localparam logic       OP_SPLIT = 1'b0;
  localparam logic       OP_BUILD = 1'b1;
  localparam logic [31:0] SPAN_LIMIT = 32'd3155760000;
  localparam int unsigned NUM_STAGES = 6;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/epoch_seconds_calendar_converter_unit.sv
// Throughput: one item per cycle while out_stall is low; six register stages
// hold the divide, multiply, month lookup and output format steps, the output stage is the last of them.
// A stall freezes the whole pipe; in_stall follows out_stall.
// Reset (rst_n low, synchronous) clears every stage valid bit.
module epoch_seconds_calendar_converter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  escc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output escc_pkg::out_item_t out_item
);

  typedef struct packed {
    logic        op;
    logic        bad;
    logic [31:0] t;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [6:0]  yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [31:0] acc;
  } work_t;

  logic  [escc_pkg::NUM_STAGES-1:0] v_r;
  work_t w1_r, w2_r, w3_r, w4_r, w5_r;
  work_t w1_nxt, w2_nxt, w3_nxt, w4_nxt, w5_nxt;
  escc_pkg::out_item_t o_r, o_nxt;
  logic adv;

  assign adv       = !out_stall;
  assign in_stall  = out_stall;
  assign out_valid = v_r[escc_pkg::NUM_STAGES-1];
  assign out_item  = o_r;

  // stage 1: seconds split, build day base
  logic [31:0] q60a;
  logic [63:0] p60a;
  logic [15:0] ydays;
  logic [6:0]  ym;
  assign p60a = {32'd0, in_item.seconds_count} * 64'd2290649225;
  assign q60a = 32'(p60a[63:37]);
  assign ym   = in_item.year;
  always_comb begin
    w1_nxt = '0;
    w1_nxt.op  = in_item.operation;
    ydays = 16'(ym) * 16'd365 + ((16'(ym) + 16'd3) >> 2);
    if (in_item.operation == escc_pkg::OP_SPLIT) begin
      w1_nxt.bad = in_item.seconds_count >= escc_pkg::SPAN_LIMIT;
      w1_nxt.sec = 6'(in_item.seconds_count - q60a * 32'd60);
      w1_nxt.t   = q60a;
    end else begin
      w1_nxt.bad = (in_item.month < 4'd1) || (in_item.month > 4'd12);
      w1_nxt.acc = 32'(ydays) + 32'(escc_pkg::month_start(in_item.month))
                 + 32'(in_item.day)
                 + 32'((in_item.month > 4'd2 && ym[1:0] == 2'd0) ? 1 : 0) - 32'd1;
      w1_nxt.hr  = in_item.hour;
      w1_nxt.min = in_item.minute;
      w1_nxt.sec = in_item.second;
    end
  end

  // stage 2: minutes split / days*24+h
  logic [63:0] p60b;
  logic [31:0] q60b;
  assign p60b = {32'd0, w1_r.t} * 64'd2290649225;
  assign q60b = 32'(p60b[63:37]);
  always_comb begin
    w2_nxt = w1_r;
    if (w1_r.op == escc_pkg::OP_SPLIT) begin
      w2_nxt.min = 6'(w1_r.t - q60b * 32'd60);
      w2_nxt.t   = q60b;
    end else begin
      w2_nxt.acc = w1_r.acc * 32'd24 + 32'(w1_r.hr);
    end
  end

  // stage 3: hours split / *60+min
  logic [63:0] p24;
  logic [31:0] q24;
  assign p24 = {32'd0, w2_r.t} * 64'd2863311531;
  assign q24 = 32'(p24[63:36]);
  always_comb begin
    w3_nxt = w2_r;
    if (w2_r.op == escc_pkg::OP_SPLIT) begin
      w3_nxt.hr = 5'(w2_r.t - q24 * 32'd24);
      w3_nxt.t  = q24;
    end else begin
      w3_nxt.acc = w2_r.acc * 32'd60 + 32'(w2_r.min);
    end
  end

  // stage 4: year from days (4-year cycles of 1461) / *60+sec
  logic [31:0] cyc, rem4, yrem;
  logic [1:0]  yin;
  logic [63:0] p1461;
  assign p1461 = {32'd0, w3_r.t} * 64'd2939745; // 2^32/1461 rounded up
  always_comb begin
    w4_nxt = w3_r;
    cyc  = 32'(p1461[63:32]);
    rem4 = w3_r.t - cyc * 32'd1461;
    if (rem4 >= 32'd1461) begin
      cyc  = cyc + 32'd1;
      rem4 = rem4 - 32'd1461;
    end
    if (rem4 < 32'd366) begin
      yin = 2'd0; yrem = rem4;
    end else if (rem4 < 32'd731) begin
      yin = 2'd1; yrem = rem4 - 32'd366;
    end else if (rem4 < 32'd1096) begin
      yin = 2'd2; yrem = rem4 - 32'd731;
    end else begin
      yin = 2'd3; yrem = rem4 - 32'd1096;
    end
    if (w3_r.op == escc_pkg::OP_SPLIT) begin
      w4_nxt.yr = 7'({cyc[4:0], yin});
      w4_nxt.t  = yrem;
    end else begin
      w4_nxt.acc = w3_r.acc * 32'd60 + 32'(w3_r.sec);
    end
  end

  // stage 5: month and day
  logic       lp;
  logic [8:0] lim, st;
  always_comb begin
    w5_nxt = w4_r;
    lp = w4_r.yr[1:0] == 2'd0;
    w5_nxt.mo = 4'd1;
    st = '0;
    for (int m = 2; m <= 12; m++) begin
      lim = escc_pkg::month_start(4'(m)) + ((lp && m > 2) ? 9'd1 : 9'd0);
      if (w4_r.t[8:0] >= lim) begin
        w5_nxt.mo = 4'(m);
        st = lim;
      end
    end
    w5_nxt.dy = 5'(w4_r.t[8:0] - st + 9'd1);
  end

  // stage 6: output format
  always_comb begin
    o_nxt = '0;
    o_nxt.invalid = w5_r.bad;
    if (!w5_r.bad) begin
      if (w5_r.op == escc_pkg::OP_SPLIT) begin
        o_nxt.out_year   = w5_r.yr;
        o_nxt.out_month  = w5_r.mo;
        o_nxt.out_day    = w5_r.dy;
        o_nxt.out_hour   = w5_r.hr;
        o_nxt.out_minute = w5_r.min;
        o_nxt.out_second = w5_r.sec;
      end else begin
        o_nxt.out_seconds_count = w5_r.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[escc_pkg::NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
      w3_r <= w3_nxt;
      w4_r <= w4_nxt;
      w5_r <= w5_nxt;
      o_r  <= o_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_stall |=> $stable(v_r)) else $error("pipe moved under stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_stall && v_r[escc_pkg::NUM_STAGES-2]) |=> out_valid)
    else $error("item lost in last stage");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && o_r.invalid) |-> (o_r.out_seconds_count == '0 && o_r.out_month == '0))
    else $error("invalid result carries data");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [31:0] LAST_VALID_COUNT = 32'd3155759999;

  typedef struct {
    escc_pkg::in_item_t  stim;
    logic                has_result;
    escc_pkg::out_item_t result;
  } vector_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  escc_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  escc_pkg::out_item_t out_item;

  escc_pkg::out_item_t pending_dates[$];
  int        error_count;
  int        idle_cycles;
  bit        stim_done;

  epoch_seconds_calendar_converter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned month_days(int unsigned m, int unsigned yr);
    int unsigned len;
    case (m)
      2: len = (yr % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic escc_pkg::out_item_t convert_date(escc_pkg::in_item_t stim);
    escc_pkg::out_item_t r;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    logic [31:0] acc;
    r = '0;
    if (stim.operation == escc_pkg::OP_SPLIT) begin
      if (stim.seconds_count >= escc_pkg::SPAN_LIMIT) begin
        r.invalid = 1'b1;
      end else begin
        t = stim.seconds_count;
        r.out_second = 6'(t % 60);
        t = t / 60;
        r.out_minute = 6'(t % 60);
        t = t / 60;
        r.out_hour = 5'(t % 24);
        days = t / 24;
        yr = 0;
        while (yr < 99 && days >= 365 + ((yr % 4 == 0) ? 1 : 0)) begin
          days -= 365 + ((yr % 4 == 0) ? 1 : 0);
          yr++;
        end
        mo = 1;
        while (mo < 12 && days >= month_days(mo, yr)) begin
          days -= month_days(mo, yr);
          mo++;
        end
        r.out_year = 7'(yr);
        r.out_month = 4'(mo);
        r.out_day = 5'(days + 1);
      end
    end else begin
      if (stim.month < 1 || stim.month > 12) begin
        r.invalid = 1'b1;
      end else begin
        acc = 32'(stim.day);
        for (int unsigned i = 1; i < stim.month; i++) acc += month_days(i, 1);
        if (stim.month > 2 && stim.year % 4 == 0) acc += 1;
        acc = acc + 32'd365 * stim.year + (stim.year + 32'd3) / 32'd4 - 32'd1;
        r.out_seconds_count = ((acc * 32'd24 + stim.hour) * 32'd60 + stim.minute) * 32'd60
                              + stim.second;
      end
    end
    return r;
  endfunction

  function automatic escc_pkg::in_item_t split_req(logic [31:0] count);
    escc_pkg::in_item_t s;
    s = '0;
    s.operation = escc_pkg::OP_SPLIT;
    s.seconds_count = count;
    return s;
  endfunction

  function automatic escc_pkg::in_item_t build_req(int y, int m, int d, int h, int mi, int s);
    escc_pkg::in_item_t r;
    r = '0;
    r.operation = escc_pkg::OP_BUILD;
    r.year = 7'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    return r;
  endfunction

  function automatic escc_pkg::in_item_t random_req();
    escc_pkg::in_item_t s;
    s = escc_pkg::in_item_t'(66'({$urandom, $urandom, $urandom}));
    case ($urandom_range(0, 5))
      0: s.seconds_count = $urandom;
      1, 2: begin
        s.operation = escc_pkg::OP_SPLIT;
        s.seconds_count = $urandom_range(0, LAST_VALID_COUNT);
      end
      3: begin
        s.operation = escc_pkg::OP_SPLIT;
        s.seconds_count = escc_pkg::SPAN_LIMIT + $urandom_range(0, 3) - 2;
      end
      default: begin
        s.operation = escc_pkg::OP_BUILD;
        s.year = 7'($urandom_range(0, 99));
        s.month = 4'($urandom_range(1, 12));
        s.day = 5'($urandom_range(1, 31));
        s.hour = 5'($urandom_range(0, 23));
        s.minute = 6'($urandom_range(0, 59));
        s.second = 6'($urandom_range(0, 59));
      end
    endcase
    return s;
  endfunction

  task automatic send_date(escc_pkg::in_item_t stim, escc_pkg::out_item_t want);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= stim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dates.push_back(want);
  endtask

  vector_t table_rows[$];

  task automatic add_row(escc_pkg::in_item_t stim, logic has_r, escc_pkg::out_item_t r);
    vector_t v;
    v.stim = stim;
    v.has_result = has_r;
    v.result = r;
    table_rows.push_back(v);
  endtask

  initial begin
    escc_pkg::out_item_t bad;
    escc_pkg::out_item_t epoch;
    escc_pkg::in_item_t  stim;
    bad = '0;
    bad.invalid = 1'b1;
    epoch = '0;
    epoch.out_year = 7'd0;
    epoch.out_month = 4'd1;
    epoch.out_day = 5'd1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    stim_done = 1'b0;
    error_count = 0;
    add_row(split_req(32'd0), 1'b1, epoch);
    add_row(split_req(escc_pkg::SPAN_LIMIT), 1'b1, bad);
    add_row(split_req(32'hFFFF_FFFF), 1'b1, bad);
    add_row(split_req(LAST_VALID_COUNT), 1'b0, '0);
    add_row(split_req(32'd5097599), 1'b0, '0);
    add_row(split_req(32'd5184000), 1'b0, '0);
    add_row(split_req(32'd31622399), 1'b0, '0);
    add_row(split_req(32'd31622400), 1'b0, '0);
    add_row(build_req(0, 1, 1, 0, 0, 0), 1'b1, '0);
    add_row(build_req(0, 0, 1, 0, 0, 0), 1'b1, bad);
    add_row(build_req(0, 13, 1, 0, 0, 0), 1'b1, bad);
    add_row(build_req(127, 15, 31, 31, 63, 63), 1'b1, bad);
    add_row(build_req(0, 1, 0, 0, 0, 0), 1'b0, '0);
    add_row(build_req(99, 12, 31, 23, 59, 59), 1'b0, '0);
    add_row(build_req(127, 12, 31, 31, 63, 63), 1'b0, '0);
    add_row(build_req(4, 2, 29, 12, 30, 30), 1'b0, '0);
    add_row(build_req(4, 3, 1, 0, 0, 0), 1'b0, '0);
    add_row(build_req(3, 3, 1, 0, 0, 0), 1'b0, '0);
    add_row(build_req(68, 6, 15, 7, 45, 1), 1'b0, '0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].has_result) send_date(table_rows[i].stim, table_rows[i].result);
      else send_date(table_rows[i].stim, convert_date(table_rows[i].stim));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
      end
      stim = random_req();
      send_date(stim, convert_date(stim));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      wait_cycles = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    escc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected item expected none actual %h", $time, out_item);
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_item.out_year !== want.out_year || out_item.out_month !== want.out_month
            || out_item.out_day !== want.out_day || out_item.out_hour !== want.out_hour
            || out_item.out_minute !== want.out_minute
            || out_item.out_second !== want.out_second
            || out_item.out_seconds_count !== want.out_seconds_count
            || out_item.invalid !== want.invalid) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_item);
          error_count++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      if (stim_done && pending_dates.size() == 0) begin
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_dates.size() == 0) begin
          $display("tb: success");
        end else begin
          $display("tb: failure");
        end
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/escc_pkg.sv
rtl/epoch_seconds_calendar_converter_unit.sv
verif/tb_top.sv
